FILE: rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// shared width, status codes and pipeline item type of the rounded divider
// ----------------------------------------------------------------------------
package rsd_pkg;

	localparam int DATA_WIDTH = 32;

	typedef logic [DATA_WIDTH-1:0] rsd_data_t;
	typedef logic [1:0]            rsd_status_t;

	localparam rsd_status_t ST_OK   = 2'd0;
	localparam rsd_status_t ST_DIV0 = 2'd1;
	localparam rsd_status_t ST_OVF  = 2'd2;

	localparam rsd_data_t POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	// one item in flight through the divide stages
	typedef struct packed {
		logic      valid;
		logic      neg;
		logic      div0;
		rsd_data_t rem;
		rsd_data_t dq;
		rsd_data_t ay;
	} rsd_item_t;

endpackage

FILE: rtl/rsd_prep.sv
// ----------------------------------------------------------------------------
// rsd_prep
// input stage: operand magnitudes, result sign and zero divisor check
// ----------------------------------------------------------------------------
module rsd_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  rsd_pkg::rsd_data_t dividend,
	input  rsd_pkg::rsd_data_t divisor,
	output rsd_pkg::rsd_item_t item_s1
);
	import rsd_pkg::*;

	logic      nx;
	logic      ny;
	rsd_data_t ax;
	rsd_data_t ay;

	assign nx = dividend[DATA_WIDTH-1];
	assign ny = divisor[DATA_WIDTH-1];
	assign ax = nx ? (~dividend + rsd_data_t'(1)) : dividend;
	assign ay = ny ? (~divisor + rsd_data_t'(1)) : divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (en) begin
			item_s1.valid <= in_valid;
			item_s1.neg   <= nx ^ ny;
			item_s1.div0  <= (ay == '0);
			item_s1.rem   <= '0;
			item_s1.dq    <= ax;
			item_s1.ay    <= ay;
		end
	end

endmodule

FILE: rtl/rsd_div_stage.sv
// ----------------------------------------------------------------------------
// rsd_div_stage
// one restoring division step: one quotient bit per stage
// ----------------------------------------------------------------------------
module rsd_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  rsd_pkg::rsd_item_t item_in,
	output rsd_pkg::rsd_item_t item_out
);
	import rsd_pkg::*;

	logic [DATA_WIDTH:0] sh;
	logic [DATA_WIDTH:0] diff;
	logic                ge;

	assign sh   = {item_in.rem, item_in.dq[DATA_WIDTH-1]};
	assign diff = sh - {1'b0, item_in.ay};
	assign ge   = ~diff[DATA_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_out <= '0;
		end else if (en) begin
			item_out.valid <= item_in.valid;
			item_out.neg   <= item_in.neg;
			item_out.div0  <= item_in.div0;
			item_out.rem   <= ge ? diff[DATA_WIDTH-1:0] : sh[DATA_WIDTH-1:0];
			item_out.dq    <= {item_in.dq[DATA_WIDTH-2:0], ge};
			item_out.ay    <= item_in.ay;
		end
	end

endmodule

FILE: rtl/rsd_post.sv
// ----------------------------------------------------------------------------
// rsd_post
// rounding stage, then sign, saturation and status into the output register
// ----------------------------------------------------------------------------
module rsd_post (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  rsd_pkg::rsd_item_t   item_in,
	output logic                 out_valid,
	output rsd_pkg::rsd_data_t   quotient,
	output rsd_pkg::rsd_status_t status
);
	import rsd_pkg::*;

	logic                valid_s1;
	logic                neg_s1;
	logic                div0_s1;
	logic [DATA_WIDTH:0] q_s1;
	logic                round_up;
	rsd_data_t           q_neg;

	// round half away from zero: twice the remainder at least the divisor
	assign round_up = ({item_in.rem, 1'b0} >= {1'b0, item_in.ay});
	assign q_neg    = ~q_s1[DATA_WIDTH-1:0] + rsd_data_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= item_in.valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= item_in.neg;
			div0_s1 <= item_in.div0;
			q_s1    <= {1'b0, item_in.dq} + {{DATA_WIDTH{1'b0}}, round_up};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (div0_s1) begin
				quotient <= '0;
				status   <= ST_DIV0;
			end else if (neg_s1) begin
				quotient <= q_neg;
				status   <= ST_OK;
			end else if (q_s1 > {1'b0, POS_MAX}) begin
				quotient <= POS_MAX;
				status   <= ST_OVF;
			end else begin
				quotient <= q_s1[DATA_WIDTH-1:0];
				status   <= ST_OK;
			end
		end
	end

endmodule

FILE: rtl/rounded_signed_divider.sv
// ----------------------------------------------------------------------------
// rounded_signed_divider
// signed division with the quotient rounded to nearest, ties away from zero
// ----------------------------------------------------------------------------
// Fully pipelined: one operand pair is taken every cycle unless a result
// waits on out_stall. One stage forms the operand magnitudes, one restoring
// step per quotient bit follows, then one stage rounds and one applies sign
// and saturation into the output register. A stalled result freezes the
// whole pipeline, so in_stall follows out_stall while a result is waiting.
// A zero divisor gives quotient 0 with status 1; the most negative dividend
// over minus one saturates to the largest positive value with status 2.
// ----------------------------------------------------------------------------
module rounded_signed_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rsd_pkg::rsd_data_t   dividend,
	input  rsd_pkg::rsd_data_t   divisor,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rsd_pkg::rsd_data_t   quotient,
	output rsd_pkg::rsd_status_t status
);
	import rsd_pkg::*;

	logic      en;
	rsd_item_t item_a [0:DATA_WIDTH];

	assign en       = ~(out_valid & out_stall);
	assign in_stall = ~en;

	rsd_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.dividend (dividend),
		.divisor  (divisor),
		.item_s1  (item_a[0])
	);

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_div
		rsd_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.item_in  (item_a[i]),
			.item_out (item_a[i+1])
		);
	end

	rsd_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.item_in   (item_a[DATA_WIDTH]),
		.out_valid (out_valid),
		.quotient  (quotient),
		.status    (status)
	);

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIV0 |-> quotient == '0)
		else $error("divide by zero transaction with nonzero quotient");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OVF |-> quotient == POS_MAX)
		else $error("overflow transaction not saturated");

	a_no_code3: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(item_a[0]))
		else $error("pipeline moved while frozen");

endmodule
